### rtl/hld_pkg.sv
// ----------------------------------------------------------------------------
// hld_pkg
// Shared constants for the HI/LO divide unit: data width, step counter
// width and the command codes.
// ----------------------------------------------------------------------------
package hld_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  // Command codes carried in cmd_i
  localparam logic [1:0] CMD_SDIV = 2'd0;
  localparam logic [1:0] CMD_UDIV = 2'd1;
  localparam logic [1:0] CMD_WHI  = 2'd2;
  localparam logic [1:0] CMD_WLO  = 2'd3;

endpackage : hld_pkg

### rtl/hld_divider.sv
// ----------------------------------------------------------------------------
// hld_divider
// Radix-2 restoring divider on unsigned magnitudes. The dividend shifts
// out of the quotient register one bit per cycle into the partial
// remainder, while quotient bits shift in behind it.
// ----------------------------------------------------------------------------
module hld_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hld_pkg::DATA_W-1:0]  dividend_i,
  input  logic [hld_pkg::DATA_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [hld_pkg::DATA_W-1:0]  quotient_o,
  output logic [hld_pkg::DATA_W-1:0]  remainder_o
);
  import hld_pkg::*;

  localparam logic [CNT_W-1:0] CntLast = CNT_W'(DATA_W - 1);

  logic                run_q, run_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DATA_W-1:0]   quo_q, quo_d;
  logic [DATA_W-1:0]   rem_q, rem_d;
  logic [DATA_W-1:0]   dvs_q, dvs_d;
  logic [DATA_W:0]     trial;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, dvs_q};

  // Load on start, then one quotient bit per cycle
  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CntLast;
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      if (!trial[DATA_W]) begin
        rem_d = trial[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = run_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule : hld_divider

### rtl/hi_lo_divide_unit_top.sv
// ----------------------------------------------------------------------------
// hi_lo_divide_unit_top
// Divide unit with HI and LO registers. Each input word is a signed
// divide, an unsigned divide, a write of HI or a write of LO; each gives
// one output word holding HI and LO after the command.
//
// Channels: the input word (cmd_i, operand_a_i, operand_b_i) is taken on a
// rising edge with in_valid_i high and in_stall_o low. The output word
// (hi_value_o, lo_value_o) is taken with out_valid_o high and out_stall_i
// low. Both sides hold valid and payload while stalled.
// An accepted divide runs the radix-2 divider loop, one quotient bit
// each step, then a final step restores the signs and writes HI and
// LO. A write of HI or LO passes through the work state to the output.
// One command is in work at a time; the next is taken in the cycle
// after the result is posted.
// Reset clears HI and LO to zero and empties the output.
// A stalled receiver holds the output word; a finished command then waits
// until the output register frees, and no new command is taken meanwhile.
// ----------------------------------------------------------------------------
module hi_lo_divide_unit_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic [hld_pkg::DATA_W-1:0]  operand_a_i,
  input  logic [hld_pkg::DATA_W-1:0]  operand_b_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [hld_pkg::DATA_W-1:0]  hi_value_o,
  output logic [hld_pkg::DATA_W-1:0]  lo_value_o
);
  import hld_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic                state_q, state_d;
  logic [1:0]          cmd_q, cmd_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic                qneg_q, qneg_d;
  logic                rneg_q, rneg_d;
  logic [DATA_W-1:0]   hi_q, hi_d;
  logic [DATA_W-1:0]   lo_q, lo_d;
  logic                out_valid_q, out_valid_d;

  logic                in_accept;
  logic                is_div;
  logic                a_neg, b_neg;
  logic [DATA_W-1:0]   a_mag, b_mag;
  logic                div_busy;
  logic [DATA_W-1:0]   div_quo, div_rem;
  logic                slot_free;
  logic                finish;
  logic [DATA_W-1:0]   quo_fix, rem_fix;

  assign in_accept = in_valid_i && !in_stall_o;
  assign is_div    = (cmd_i == CMD_SDIV) || (cmd_i == CMD_UDIV);

  // Take signed operands to magnitudes on the way in
  assign a_neg = (cmd_i == CMD_SDIV) && operand_a_i[DATA_W-1];
  assign b_neg = (cmd_i == CMD_SDIV) && operand_b_i[DATA_W-1];
  assign a_mag = a_neg ? (DATA_W'(0) - operand_a_i) : operand_a_i;
  assign b_mag = b_neg ? (DATA_W'(0) - operand_b_i) : operand_b_i;

  hld_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept && is_div),
    .dividend_i  (a_mag),
    .divisor_i   (b_mag),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Restore signs: quotient by sign mismatch, remainder follows dividend
  assign quo_fix = qneg_q ? (DATA_W'(0) - div_quo) : div_quo;
  assign rem_fix = rneg_q ? (DATA_W'(0) - div_rem) : div_rem;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign finish    = (state_q == S_WORK) && !div_busy && slot_free;

  // Sequence one command at a time and post its result
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    qneg_d      = qneg_q;
    rneg_d      = rneg_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_WORK;
          cmd_d   = cmd_i;
          val_d   = operand_a_i;
          qneg_d  = a_neg != b_neg;
          rneg_d  = a_neg;
        end
      end
      S_WORK: begin
        if (finish) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          case (cmd_q)
            CMD_SDIV: begin
              hi_d = rem_fix;
              lo_d = quo_fix;
            end
            CMD_UDIV: begin
              hi_d = div_rem;
              lo_d = div_quo;
            end
            CMD_WHI: hi_d = val_q;
            CMD_WLO: lo_d = val_q;
            default: begin
              hi_d = hi_q;
              lo_d = lo_q;
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and architectural HI/LO
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hi_q        <= '0;
      lo_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hi_q        <= hi_d;
      lo_q        <= lo_d;
    end
  end

  // Command payload
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    val_q  <= val_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign hi_value_o  = hi_q;
  assign lo_value_o  = lo_q;

  // Divider only runs while a command is in work
  a_busy_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == S_WORK))
    else $error("divider busy outside of work state");

  // An accepted divide starts the divider
  a_div_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_div) |=> div_busy)
    else $error("accepted divide did not start the divider");

  // A new output word only follows a finished command
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_WORK))
    else $error("output posted without a command in work");

  // HI and LO change only when a result is posted
  a_hilo_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !finish |=> ($stable(hi_q) && $stable(lo_q)))
    else $error("HI or LO changed without a finished command");

endmodule : hi_lo_divide_unit_top
